### rtl/rzts_pkg.sv
// Shared types and constants of the rotozoom texture sampler.
package rzts_pkg;

    // Default sizes handed to the top-level parameters
    localparam int TEX_SIZE_DEF = 128;
    localparam int MAX_DIM_DEF  = 1024;

    // Fixed field widths
    localparam int FRAME_W   = 11;
    localparam int COEF_W    = 16;
    localparam int PIXEL_W   = 10;
    localparam int TEXEL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Coefficients are Q3.12 and offsets Q.2, so products carry 14 fraction bits
    localparam int FRAC_SHIFT = 14;

    // Result queue depth; also the number of render beats allowed in flight
    localparam int OUT_DEPTH = 8;

    // Input beat modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Register reset values
    localparam logic [FRAME_W-1:0]       FRAME_WIDTH_RST  = FRAME_W'(80);
    localparam logic [FRAME_W-1:0]       FRAME_HEIGHT_RST = FRAME_W'(25);
    localparam logic signed [COEF_W-1:0] COS_ZOOM_RST     = COEF_W'(4096);
    localparam logic signed [COEF_W-1:0] SIN_ZOOM_RST     = COEF_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COS_ZOOM     = 2'd2,
        CFG_SIN_ZOOM     = 2'd3
    } t_cfg_index;

    // Control carried alongside each pipeline stage
    typedef struct packed {
        logic valid;
        logic write;
    } t_stage_ctl;

endpackage

### rtl/rzts_coord.sv
// Coordinate pipeline: centre, rotate and scale, truncate and wrap to texture space.
module rzts_coord
    import rzts_pkg::*;
#(
    parameter int TEX_SIZE = TEX_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF,
    localparam int TEX_BITS = $clog2(TEX_SIZE),
    localparam int ADDR_W   = 2 * TEX_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_stage_ctl                i_ctl,
    input  logic [ADDR_W-1:0]         i_texel_address,
    input  logic [TEXEL_W-1:0]        i_texel_value,
    input  logic [PIXEL_W-1:0]        i_pixel_x,
    input  logic [PIXEL_W-1:0]        i_pixel_y,
    input  logic [FRAME_W-1:0]        i_frame_width,
    input  logic [FRAME_W-1:0]        i_frame_height,
    input  logic signed [COEF_W-1:0]  i_cos_zoom,
    input  logic signed [COEF_W-1:0]  i_sin_zoom,
    output t_stage_ctl                o_ctl,
    output logic [ADDR_W-1:0]         o_addr,
    output logic [TEXEL_W-1:0]        o_data,
    output logic [TEX_BITS-1:0]       o_u,
    output logic [TEX_BITS-1:0]       o_v
);

    localparam int SPAN    = (MAX_DIM > 1024) ? MAX_DIM : 1024;
    localparam int DELTA_W = $clog2(SPAN) + 3;
    localparam int PROD_W  = DELTA_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;

    t_stage_ctl r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [ADDR_W-1:0]  r_addr1, r_addr2, r_addr3, r_addr4;
    logic [TEXEL_W-1:0] r_data1, r_data2, r_data3, r_data4;

    logic signed [DELTA_W-1:0] r_dx4, r_dy4;
    logic signed [PROD_W-1:0]  r_xc, r_ys, r_xs, r_yc;
    logic signed [SUM_W-1:0]   r_pu, r_pv;
    logic [TEX_BITS-1:0]       r_u, r_v;

    logic [DELTA_W-1:0]        w_ext, h_ext, w_cl, h_cl;
    logic signed [DELTA_W-1:0] n_dx4, n_dy4;
    logic signed [SUM_W-1:0]   bias_u, bias_v, adj_u, adj_v;
    logic [TEX_BITS-1:0]       n_u, n_v;

    // Stage 1: clamp frame size, centre with halved horizontal offset (Q.2)
    always_comb begin
        w_ext = DELTA_W'(i_frame_width);
        h_ext = DELTA_W'(i_frame_height);
        w_cl  = (w_ext > DELTA_W'(MAX_DIM)) ? DELTA_W'(MAX_DIM) : w_ext;
        h_cl  = (h_ext > DELTA_W'(MAX_DIM)) ? DELTA_W'(MAX_DIM) : h_ext;
        n_dx4 = $signed(DELTA_W'({i_pixel_x, 1'b0}) - w_cl);
        n_dy4 = $signed(DELTA_W'({i_pixel_y, 2'b00}) - DELTA_W'({h_cl, 1'b0}));
    end

    // Stage 4: truncate toward zero, keep the low bits as the wrap
    always_comb begin
        bias_u = r_pu[SUM_W-1] ? SUM_W'((1 << FRAC_SHIFT) - 1) : '0;
        bias_v = r_pv[SUM_W-1] ? SUM_W'((1 << FRAC_SHIFT) - 1) : '0;
        adj_u  = r_pu + bias_u;
        adj_v  = r_pv + bias_v;
        n_u    = adj_u[FRAC_SHIFT +: TEX_BITS];
        n_v    = adj_v[FRAC_SHIFT +: TEX_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr1 <= i_texel_address;
        r_data1 <= i_texel_value;
        r_dx4   <= n_dx4;
        r_dy4   <= n_dy4;

        r_addr2 <= r_addr1;
        r_data2 <= r_data1;
        r_xc    <= PROD_W'(r_dx4) * PROD_W'(i_cos_zoom);
        r_ys    <= PROD_W'(r_dy4) * PROD_W'(i_sin_zoom);
        r_xs    <= PROD_W'(r_dx4) * PROD_W'(i_sin_zoom);
        r_yc    <= PROD_W'(r_dy4) * PROD_W'(i_cos_zoom);

        r_addr3 <= r_addr2;
        r_data3 <= r_data2;
        r_pu    <= SUM_W'(r_xc) - SUM_W'(r_ys);
        r_pv    <= SUM_W'(r_xs) + SUM_W'(r_yc);

        r_data4 <= r_data3;
        r_u     <= n_u;
        r_v     <= n_v;
        r_addr4 <= r_ctl3.write ? r_addr3 : {n_v, n_u};
    end

    assign o_ctl  = r_ctl4;
    assign o_addr = r_addr4;
    assign o_data = r_data4;
    assign o_u    = r_u;
    assign o_v    = r_v;

endmodule

### rtl/rzts_tex_mem.sv
// Texture store: one synchronous write or one registered read per cycle.
module rzts_tex_mem
    import rzts_pkg::*;
#(
    parameter int TEX_SIZE = TEX_SIZE_DEF,
    localparam int TEX_BITS = $clog2(TEX_SIZE),
    localparam int ADDR_W   = 2 * TEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [TEXEL_W-1:0]  i_data,
    input  logic [TEX_BITS-1:0] i_u,
    input  logic [TEX_BITS-1:0] i_v,
    output logic                o_valid,
    output logic [TEXEL_W-1:0]  o_rdata,
    output logic [TEX_BITS-1:0] o_u,
    output logic [TEX_BITS-1:0] o_v
);

    logic [TEXEL_W-1:0] r_mem [TEX_SIZE*TEX_SIZE];
    logic               r_valid;
    logic [TEXEL_W-1:0] r_rdata;
    logic [TEX_BITS-1:0] r_u, r_v;

    // Items arrive in order and one per cycle, so a read always sees every earlier write
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && i_ctl.write) begin
            r_mem[i_addr] <= i_data;
        end
        if (i_ctl.valid && !i_ctl.write) begin
            r_rdata <= r_mem[i_addr];
            r_u     <= i_u;
            r_v     <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid && !i_ctl.write;
        end
    end

    assign o_valid = r_valid;
    assign o_rdata = r_rdata;
    assign o_u     = r_u;
    assign o_v     = r_v;

endmodule

### rtl/rzts_out_fifo.sv
// Result queue that decouples the fixed-latency pipeline from output back-pressure.
module rzts_out_fifo
    import rzts_pkg::*;
#(
    parameter int DEPTH  = OUT_DEPTH,
    parameter int DATA_W = 8,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic [CNT_W-1:0]  o_count
);

    logic [DATA_W-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign pop = (r_count != '0) && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/rotozoom_texture_sampler.sv
// Top level of the rotozoom texture sampler: registers, pipeline, texture store, result queue.
//
// The sampler keeps a TEX_SIZE x TEX_SIZE store of 8-bit texels and takes one
// beat per cycle on its input channel. A beat with mode 0 writes one texel at
// row*TEX_SIZE+column and produces no result. A beat with mode 1 names a
// screen pixel: the pixel is centred on the frame (horizontal offset halved),
// rotated and scaled by cos_zoom and sin_zoom (signed Q3.12), truncated toward
// zero, wrapped to the texture and looked up; the result beat carries the
// texel and the wrapped column and row. Throughput is one beat per cycle in
// either direction while neither channel stalls; a render result passes
// through the four coordinate stages, the registered memory read and the
// result queue. Up to eight renders may be in flight or queued; the input
// stalls only while eight renders are outstanding, that is accepted but not
// yet taken on the result channel. Writes and
// renders share one in-order path to the store, so a render always sees every
// earlier write. Texels must be written before they are read; the store is
// not cleared at reset. TEX_SIZE must be a power of two. Frame sizes above
// MAX_DIM saturate at MAX_DIM. Change the configuration registers only while
// no render is in flight.
module rotozoom_texture_sampler
    import rzts_pkg::*;
#(
    parameter int TEX_SIZE = TEX_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF,
    localparam int TEX_BITS = $clog2(TEX_SIZE),
    localparam int ADDR_W   = 2 * TEX_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [ADDR_W-1:0]    i_texel_address,
    input  logic [TEXEL_W-1:0]   i_texel_value,
    input  logic [PIXEL_W-1:0]   i_pixel_x,
    input  logic [PIXEL_W-1:0]   i_pixel_y,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [TEXEL_W-1:0]   o_pixel_value,
    output logic [TEX_BITS-1:0]  o_tex_u,
    output logic [TEX_BITS-1:0]  o_tex_v
);

    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int RES_W  = TEXEL_W + 2 * TEX_BITS;

    // Configuration registers
    logic [FRAME_W-1:0]       r_frame_width, r_frame_height;
    logic signed [COEF_W-1:0] r_cos_zoom, r_sin_zoom;

    // Render credits: renders accepted whose result beat has not left yet
    logic [CNT_W-1:0] r_credit;

    logic          in_beat, out_beat, render_beat;
    t_stage_ctl    in_ctl, coord_ctl;
    logic [ADDR_W-1:0]   coord_addr;
    logic [TEXEL_W-1:0]  coord_data;
    logic [TEX_BITS-1:0] coord_u, coord_v;
    logic                mem_valid;
    logic [TEXEL_W-1:0]  mem_rdata;
    logic [TEX_BITS-1:0] mem_u, mem_v;
    logic [RES_W-1:0]    res_data;
    logic [CNT_W-1:0]    fifo_count;

    // Stall input only while every queue slot is spoken for
    assign o_ready     = (r_credit < CNT_W'(OUT_DEPTH));
    assign in_beat     = i_valid && o_ready;
    assign render_beat = in_beat && (i_mode == MODE_RENDER);
    assign out_beat    = o_valid && i_ready;

    assign in_ctl.valid = in_beat;
    assign in_ctl.write = (i_mode == MODE_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_cos_zoom     <= COS_ZOOM_RST;
            r_sin_zoom     <= SIN_ZOOM_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FRAME_W-1:0];
                CFG_COS_ZOOM:     r_cos_zoom     <= $signed(i_cfg_wdata[COEF_W-1:0]);
                CFG_SIN_ZOOM:     r_sin_zoom     <= $signed(i_cfg_wdata[COEF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Take a credit on each accepted render, return it when its result beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (render_beat && !out_beat) begin
            r_credit <= r_credit + CNT_W'(1);
        end else if (!render_beat && out_beat) begin
            r_credit <= r_credit - CNT_W'(1);
        end
    end

    rzts_coord #(
        .TEX_SIZE (TEX_SIZE),
        .MAX_DIM  (MAX_DIM)
    ) u_coord (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (in_ctl),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_cos_zoom      (r_cos_zoom),
        .i_sin_zoom      (r_sin_zoom),
        .o_ctl           (coord_ctl),
        .o_addr          (coord_addr),
        .o_data          (coord_data),
        .o_u             (coord_u),
        .o_v             (coord_v)
    );

    rzts_tex_mem #(
        .TEX_SIZE (TEX_SIZE)
    ) u_tex_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (coord_ctl),
        .i_addr  (coord_addr),
        .i_data  (coord_data),
        .i_u     (coord_u),
        .i_v     (coord_v),
        .o_valid (mem_valid),
        .o_rdata (mem_rdata),
        .o_u     (mem_u),
        .o_v     (mem_v)
    );

    rzts_out_fifo #(
        .DEPTH  (OUT_DEPTH),
        .DATA_W (RES_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mem_valid),
        .i_data  ({mem_rdata, mem_u, mem_v}),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res_data),
        .o_count (fifo_count)
    );

    assign o_pixel_value = res_data[RES_W-1 -: TEXEL_W];
    assign o_tex_u       = res_data[2*TEX_BITS-1 -: TEX_BITS];
    assign o_tex_v       = res_data[TEX_BITS-1:0];

    // Credits bound the queue, so a push never meets a full queue
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CNT_W'(OUT_DEPTH))
        else $error("render credit count above queue depth");

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= r_credit)
        else $error("queued results exceed outstanding renders");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_credit != '0)
        else $error("result beat without an outstanding render");

    a_render_takes_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (render_beat && !out_beat) |=> r_credit == $past(r_credit) + CNT_W'(1))
        else $error("accepted render did not take a credit");

endmodule
